// ----- sv/mtd_pkg.sv -----
// Shared types, constants and the code table for the Morse text decoder.
// No dependencies; used by mtd_state_mem, mtd_step and morse_text_decoder.
package mtd_pkg;

	localparam int CODE_W = 7;
	localparam int LEN_W  = 4;
	localparam int SYM_W  = 7;

	// longest run that is looked up; one more marks an overlong run
	localparam logic [LEN_W-1:0] MAX_CODE_LEN = LEN_W'(7);

	localparam logic [7:0]       CH_DOT   = 8'h2E;
	localparam logic [7:0]       CH_DASH  = 8'h2D;
	localparam logic [7:0]       CH_SPACE = 8'h20;
	localparam logic [SYM_W-1:0] SYM_SPACE = 7'h20;

	typedef struct packed {
		logic [CODE_W-1:0] code;
		logic [LEN_W-1:0]  len;
	} run_state_t;

	localparam int STATE_W = CODE_W + LEN_W;

	typedef struct packed {
		logic             hit;
		logic [SYM_W-1:0] ch;
	} sym_res_t;

	// Look up a run (dash = 1, first symbol most significant).
	function automatic sym_res_t lookup_code(input logic [LEN_W-1:0] len,
			input logic [CODE_W-1:0] code);
		sym_res_t r;
		r.hit = 1'b1;
		case ({len, code})
			{4'd1, 7'b0}:       r.ch = 7'h45; // E
			{4'd1, 7'b1}:       r.ch = 7'h54; // T
			{4'd2, 7'b01}:      r.ch = 7'h41; // A
			{4'd2, 7'b00}:      r.ch = 7'h49; // I
			{4'd2, 7'b11}:      r.ch = 7'h4D; // M
			{4'd2, 7'b10}:      r.ch = 7'h4E; // N
			{4'd3, 7'b100}:     r.ch = 7'h44; // D
			{4'd3, 7'b110}:     r.ch = 7'h47; // G
			{4'd3, 7'b101}:     r.ch = 7'h4B; // K
			{4'd3, 7'b111}:     r.ch = 7'h4F; // O
			{4'd3, 7'b010}:     r.ch = 7'h52; // R
			{4'd3, 7'b000}:     r.ch = 7'h53; // S
			{4'd3, 7'b001}:     r.ch = 7'h55; // U
			{4'd3, 7'b011}:     r.ch = 7'h57; // W
			{4'd4, 7'b1000}:    r.ch = 7'h42; // B
			{4'd4, 7'b1010}:    r.ch = 7'h43; // C
			{4'd4, 7'b0010}:    r.ch = 7'h46; // F
			{4'd4, 7'b0000}:    r.ch = 7'h48; // H
			{4'd4, 7'b0111}:    r.ch = 7'h4A; // J
			{4'd4, 7'b0100}:    r.ch = 7'h4C; // L
			{4'd4, 7'b0110}:    r.ch = 7'h50; // P
			{4'd4, 7'b1101}:    r.ch = 7'h51; // Q
			{4'd4, 7'b0001}:    r.ch = 7'h56; // V
			{4'd4, 7'b1001}:    r.ch = 7'h58; // X
			{4'd4, 7'b1011}:    r.ch = 7'h59; // Y
			{4'd4, 7'b1100}:    r.ch = 7'h5A; // Z
			{4'd5, 7'b01111}:   r.ch = 7'h31; // 1
			{4'd5, 7'b00111}:   r.ch = 7'h32; // 2
			{4'd5, 7'b00011}:   r.ch = 7'h33; // 3
			{4'd5, 7'b00001}:   r.ch = 7'h34; // 4
			{4'd5, 7'b00000}:   r.ch = 7'h35; // 5
			{4'd5, 7'b10000}:   r.ch = 7'h36; // 6
			{4'd5, 7'b11000}:   r.ch = 7'h37; // 7
			{4'd5, 7'b11100}:   r.ch = 7'h38; // 8
			{4'd5, 7'b11110}:   r.ch = 7'h39; // 9
			{4'd5, 7'b11111}:   r.ch = 7'h30; // 0
			{4'd5, 7'b10010}:   r.ch = 7'h2F; // slash
			{4'd5, 7'b10110}:   r.ch = 7'h28; // open bracket
			{4'd5, 7'b01000}:   r.ch = 7'h26; // ampersand
			{4'd5, 7'b10001}:   r.ch = 7'h3D; // equals
			{4'd6, 7'b010101}:  r.ch = 7'h2E; // full stop
			{4'd6, 7'b110011}:  r.ch = 7'h2C; // comma
			{4'd6, 7'b001100}:  r.ch = 7'h3F; // question mark
			{4'd6, 7'b101011}:  r.ch = 7'h21; // exclamation mark
			{4'd6, 7'b101101}:  r.ch = 7'h29; // close bracket
			{4'd6, 7'b111000}:  r.ch = 7'h3A; // colon
			{4'd6, 7'b101010}:  r.ch = 7'h3B; // semicolon
			{4'd6, 7'b100001}:  r.ch = 7'h2D; // hyphen
			{4'd6, 7'b001101}:  r.ch = 7'h5F; // underscore
			{4'd6, 7'b011010}:  r.ch = 7'h40; // at sign
			{4'd7, 7'b0001001}: r.ch = 7'h24; // dollar
			default: begin
				r.hit = 1'b0;
				r.ch  = SYM_SPACE;
			end
		endcase
		return r;
	endfunction

endpackage

// ----- sv/mtd_state_mem.sv -----
// Run state store of the Morse text decoder: one-entry synchronous memory
// with a registered read, write-first bypass and a reset valid bit. Uses mtd_pkg.
module mtd_state_mem (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               rd_en,
	input  logic               wr_en,
	input  mtd_pkg::run_state_t wr_data,
	output mtd_pkg::run_state_t rd_data
);
	import mtd_pkg::*;

	logic [STATE_W-1:0] mem_q [1];
	logic               vld_q;
	run_state_t         rd_q;

	// write the single entry
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[0] <= wr_data;
		end
	end

	// mark the entry written; until then it reads as an empty run
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (wr_en) begin
			vld_q <= 1'b1;
		end
	end

	// registered read; a write in the same cycle is forwarded
	always_ff @(posedge clk) begin
		if (rd_en) begin
			if (wr_en) begin
				rd_q <= wr_data;
			end else if (vld_q) begin
				rd_q <= run_state_t'(mem_q[0]);
			end else begin
				rd_q <= '0;
			end
		end
	end

	assign rd_data = rd_q;

	// a stored run never grows past the overlong mark
	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> wr_data.len <= MAX_CODE_LEN + LEN_W'(1))
		else $error("run length beyond overlong mark");

	// no code bits above the run length
	a_code_fits: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && wr_data.len < MAX_CODE_LEN) |->
		((wr_data.code >> wr_data.len) == '0))
		else $error("code bits above run length");

endmodule

// ----- sv/mtd_step.sv -----
// Per-character update of the Morse text decoder: extends or ends the run
// and looks up the finished code. Uses mtd_pkg.
module mtd_step (
	input  logic                cur_vld,
	input  logic [7:0]          char_in,
	input  logic                is_final,
	input  mtd_pkg::run_state_t cur,
	output mtd_pkg::run_state_t nxt,
	output mtd_pkg::sym_res_t   res
);
	import mtd_pkg::*;

	logic       is_sym;
	logic       is_dash;
	logic       end_run;
	run_state_t upd;
	sym_res_t   hit;

	assign is_sym  = (char_in == CH_DOT) || (char_in == CH_DASH);
	assign is_dash = (char_in == CH_DASH);

	// extend the run; past the limit symbols bump the count up to the overlong mark
	always_comb begin
		upd = cur;
		if (is_sym && cur.len <= MAX_CODE_LEN) begin
			if (cur.len < MAX_CODE_LEN) begin
				upd.code = {cur.code[CODE_W-2:0], is_dash};
			end
			upd.len = cur.len + LEN_W'(1);
		end
	end

	assign end_run = is_sym ? is_final : (cur.len != '0);
	assign hit     = lookup_code(upd.len, upd.code);

	// clear on end of run, otherwise keep the extended run
	assign nxt = end_run ? run_state_t'('0) : upd;

	// pick the result: decoded character, word gap, or nothing
	always_comb begin
		res.ch  = hit.ch;
		res.hit = 1'b0;
		if (cur_vld) begin
			if (end_run) begin
				res.hit = hit.hit;
			end else if (!is_sym && char_in != CH_SPACE) begin
				res.hit = 1'b1;
				res.ch  = SYM_SPACE;
			end
		end
	end

endmodule

// ----- sv/morse_text_decoder.sv -----
// Morse text decoder top level: input stage, state store, update logic and
// output register. Depends on mtd_pkg, mtd_state_mem and mtd_step.
//
// Usage: characters of a textual Morse stream ('.', '-', space, others)
// enter on char_in with is_final marking the last one; a transfer takes
// place when char_valid is high and char_stall low. Decoded ASCII
// characters and word gaps leave on symbol, transferred when symbol_valid
// is high and symbol_stall low. A character gives zero or one symbol.
// Order: a transfer puts the character in the update stage and reads the
// run state; the output register is loaded when that stage advances.
// Throughput: one character per cycle while char_stall is low. The run
// state lives in a one-entry memory read at transfer and written when the
// character leaves the update stage; the write-first bypass of that memory
// lets the next character follow straight away.
// Reset: arst_n clears the pipeline valids and the store's valid bit, so
// the run state reads as empty and no symbol is shown.
// Stall: while symbol_stall holds a waiting symbol, one more character is
// taken into the update stage; then char_stall rises until the symbol goes.
module morse_text_decoder (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      char_valid,
	output logic                      char_stall,
	input  logic [7:0]                char_in,
	input  logic                      is_final,
	output logic                      symbol_valid,
	input  logic                      symbol_stall,
	output logic [mtd_pkg::SYM_W-1:0] symbol
);
	import mtd_pkg::*;

	logic             accept;
	logic             s1_adv;
	logic             vld_s1;
	logic [7:0]       char_s1;
	logic             fin_s1;
	run_state_t       cur_st;
	run_state_t       nxt_st;
	sym_res_t         res;
	logic             out_vld_q;
	logic [SYM_W-1:0] symbol_q;

	assign s1_adv     = vld_s1 && (!out_vld_q || !symbol_stall);
	assign char_stall = vld_s1 && out_vld_q && symbol_stall;
	assign accept     = char_valid && !char_stall;

	// hold the character for the update stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (accept) begin
			vld_s1 <= 1'b1;
		end else if (s1_adv) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			char_s1 <= char_in;
			fin_s1  <= is_final;
		end
	end

	mtd_state_mem u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.wr_en   (s1_adv),
		.wr_data (nxt_st),
		.rd_data (cur_st)
	);

	mtd_step u_step (
		.cur_vld  (vld_s1),
		.char_in  (char_s1),
		.is_final (fin_s1),
		.cur      (cur_st),
		.nxt      (nxt_st),
		.res      (res)
	);

	// load the output register on advance, drop it once transferred
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (s1_adv) begin
			out_vld_q <= res.hit;
		end else if (!symbol_stall) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && res.hit) begin
			symbol_q <= res.ch;
		end
	end

	assign symbol_valid = out_vld_q;
	assign symbol       = symbol_q;

	// a held character stays in the update stage
	a_s1_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && !s1_adv) |=> vld_s1)
		else $error("character lost from update stage");

	// back-pressure only when a symbol waits and the stage is full
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		char_stall |-> (vld_s1 && out_vld_q && symbol_stall))
		else $error("input stalled without cause");

	// emitted symbols stay in the printable range of the table
	a_sym_range: assert property (@(posedge clk) disable iff (!arst_n)
		symbol_valid |-> (symbol >= SYM_W'(32) && symbol <= SYM_W'(95)))
		else $error("symbol out of range");

endmodule

// ----- tb/sv/morse_text_decoder_tb.sv -----
// Self-checking testbench for morse_text_decoder: a directed table, then random
// dot/dash runs and noise, checked against typed rows or a behavioural decoder
// in this file. Depends on mtd_pkg and the morse_text_decoder RTL.
module morse_text_decoder_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import mtd_pkg::*;

	localparam int RAND_ITEMS = 925;
	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 300;

	typedef enum logic [1:0] {
		ROW_PRED,	// expectation from the decoder model
		ROW_NONE,	// no symbol expected
		ROW_SYM		// symbol typed in the table
	} row_kind_t;

	typedef struct packed {
		logic [7:0]       ch;
		logic             fin;
		row_kind_t        kind;
		logic [SYM_W-1:0] sym;
	} stim_row_t;

	logic                clk;
	logic                arst_n;
	logic                char_valid;
	logic                char_stall;
	logic [7:0]          char_in;
	logic                is_final;
	logic                symbol_valid;
	logic                symbol_stall;
	logic [SYM_W-1:0]    symbol;

	logic [CODE_W-1:0]   run_code;
	logic [LEN_W-1:0]    run_len;
	logic [SYM_W-1:0]    pending_syms[$];
	logic [SYM_W-1:0]    want_sym;
	stim_row_t           dir_tab[25];
	int                  err_cnt;
	int                  cyc;
	bit                  in_burst;
	bit                  out_burst;
	bit                  rx_hold;

	morse_text_decoder u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.char_valid   (char_valid),
		.char_stall   (char_stall),
		.char_in      (char_in),
		.is_final     (is_final),
		.symbol_valid (symbol_valid),
		.symbol_stall (symbol_stall),
		.symbol       (symbol)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// give the ASCII character of a run, or zero when the run decodes to nothing
	function automatic logic [7:0] morse_char(input logic [LEN_W-1:0] len,
			input logic [CODE_W-1:0] code);
		logic [55:0] pat;
		pat = '0;
		if (len == 0 || len > MAX_CODE_LEN)
			return 8'h00;
		for (int i = 0; i < CODE_W; i++)
			if (i < len)
				pat = {pat[47:0], code[len-1-i] ? CH_DASH : CH_DOT};
		case (pat)
			56'("."): return "E";       56'("-"): return "T";
			56'(".-"): return "A";      56'(".."): return "I";
			56'("--"): return "M";      56'("-."): return "N";
			56'("-.."): return "D";     56'("--."): return "G";
			56'("-.-"): return "K";     56'("---"): return "O";
			56'(".-."): return "R";     56'("..."): return "S";
			56'("..-"): return "U";     56'(".--"): return "W";
			56'("-..."): return "B";    56'("-.-."): return "C";
			56'("..-."): return "F";    56'("...."): return "H";
			56'(".---"): return "J";    56'(".-.."): return "L";
			56'(".--."): return "P";    56'("--.-"): return "Q";
			56'("...-"): return "V";    56'("-..-"): return "X";
			56'("-.--"): return "Y";    56'("--.."): return "Z";
			56'(".----"): return "1";   56'("..---"): return "2";
			56'("...--"): return "3";   56'("....-"): return "4";
			56'("....."): return "5";   56'("-...."): return "6";
			56'("--..."): return "7";   56'("---.."): return "8";
			56'("----."): return "9";   56'("-----"): return "0";
			56'("-..-."): return "/";   56'("-.--."): return "(";
			56'(".-..."): return "&";   56'("-...-"): return "=";
			56'(".-.-.-"): return ".";  56'("--..--"): return ",";
			56'("..--.."): return "?";  56'("-.-.--"): return "!";
			56'("-.--.-"): return ")";  56'("---..."): return ":";
			56'("-.-.-."): return ";";  56'("-....-"): return "-";
			56'("..--.-"): return "_";  56'(".--.-."): return "@";
			56'("...-..-"): return "$";
			default: return 8'h00;
		endcase
	endfunction

	// end the pending run: look it up and clear it
	function automatic void close_run(output logic emit, output logic [SYM_W-1:0] sym);
		logic [7:0] hit_ch;
		hit_ch   = morse_char(run_len, run_code);
		run_code = '0;
		run_len  = '0;
		emit     = (hit_ch != 8'h00);
		sym      = hit_ch[SYM_W-1:0];
	endfunction

	// advance the decoder model by one character
	function automatic void decode_char(input logic [7:0] c, input logic f,
			output logic emit, output logic [SYM_W-1:0] sym);
		emit = 1'b0;
		sym  = SYM_SPACE;
		if (c == CH_DOT || c == CH_DASH) begin
			if (run_len <= MAX_CODE_LEN) begin
				if (run_len < MAX_CODE_LEN)
					run_code = {run_code[CODE_W-2:0], c == CH_DASH};
				run_len = run_len + 1'b1;
			end
			if (f)
				close_run(emit, sym);
		end else if (run_len != 0) begin
			close_run(emit, sym);
		end else if (c != CH_SPACE) begin
			emit = 1'b1;
		end
	endfunction

	task automatic report_mismatch(input string what, input logic [SYM_W-1:0] exp_v,
			input logic [SYM_W-1:0] got_v);
		err_cnt++;
		if (err_cnt <= 10)
			$display("%0t: %s: expected symbol 0x%02h, got 0x%02h", $realtime, what,
				exp_v, got_v);
	endtask

	// offer one character, hold it until its transfer, then record the expectation
	task automatic send_char(input logic [7:0] c, input logic f, input row_kind_t kind,
			input logic [SYM_W-1:0] typed_sym);
		int               gap;
		logic             emit;
		logic [SYM_W-1:0] sym;
		gap = in_burst ? 0 : $urandom_range(0, 14);
		if (gap > 0) begin
			char_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		char_valid = 1'b1;
		char_in    = c;
		is_final   = f;
		@(posedge clk);
		while (char_stall)
			@(posedge clk);
		decode_char(c, f, emit, sym);
		if (kind == ROW_SYM)
			pending_syms.push_back(typed_sym);
		else if (kind == ROW_PRED && emit)
			pending_syms.push_back(sym);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		while (pending_syms.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	// check every symbol transfer against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && symbol_valid && !symbol_stall) begin
			if (pending_syms.size() == 0) begin
				report_mismatch("unexpected symbol", '0, symbol);
			end else begin
				want_sym = pending_syms.pop_front();
				if (symbol !== want_sym)
					report_mismatch("symbol mismatch", want_sym, symbol);
			end
		end
	end

	// stop a hung run
	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (cyc == CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// receiver: draw a stall before each transfer, or hold off for a long stretch
	initial begin
		int w;
		symbol_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			w = out_burst ? 0 : $urandom_range(0, 14);
			if (rx_hold) begin
				w       = HOLD_CYCLES;
				rx_hold = 1'b0;
			end
			symbol_stall = (w > 0);
			repeat (w) @(negedge clk);
			symbol_stall = 1'b0;
			@(posedge clk);
			while (!symbol_valid)
				@(posedge clk);
			@(negedge clk);
		end
	end

	// sender: reset, directed table, random runs and noise, then the verdict
	initial begin
		int         n;
		int         len;
		logic       fin_end;
		logic [7:0] c;
		bit         held;
		bit         paused;

		arst_n     = 1'b0;
		char_valid = 1'b0;
		char_in    = '0;
		is_final   = 1'b0;
		run_code   = '0;
		run_len    = '0;
		err_cnt    = 0;
		in_burst   = 1'b0;
		out_burst  = 1'b0;
		rx_hold    = 1'b0;
		held       = 1'b0;
		paused     = 1'b0;

		dir_tab = '{
			// single dot decoded by a space, then spaces and odd bytes with no run
			'{CH_DOT,   1'b0, ROW_NONE, SYM_SPACE},
			'{CH_SPACE, 1'b0, ROW_SYM,  7'h45},
			'{CH_SPACE, 1'b0, ROW_NONE, SYM_SPACE},
			'{8'h00,    1'b0, ROW_SYM,  SYM_SPACE},
			'{8'hFF,    1'b0, ROW_SYM,  SYM_SPACE},
			// the one seven-symbol code, ended by a high byte marked final
			'{CH_DOT,   1'b0, ROW_PRED, SYM_SPACE},
			'{CH_DOT,   1'b0, ROW_PRED, SYM_SPACE},
			'{CH_DOT,   1'b0, ROW_PRED, SYM_SPACE},
			'{CH_DASH,  1'b0, ROW_PRED, SYM_SPACE},
			'{CH_DOT,   1'b0, ROW_PRED, SYM_SPACE},
			'{CH_DOT,   1'b0, ROW_PRED, SYM_SPACE},
			'{CH_DASH,  1'b0, ROW_PRED, SYM_SPACE},
			'{8'h80,    1'b1, ROW_SYM,  7'h24},
			// overlong run of dashes, ended by a final symbol
			'{CH_DASH,  1'b0, ROW_PRED, SYM_SPACE},
			'{CH_DASH,  1'b0, ROW_PRED, SYM_SPACE},
			'{CH_DASH,  1'b0, ROW_PRED, SYM_SPACE},
			'{CH_DASH,  1'b0, ROW_PRED, SYM_SPACE},
			'{CH_DASH,  1'b0, ROW_PRED, SYM_SPACE},
			'{CH_DASH,  1'b0, ROW_PRED, SYM_SPACE},
			'{CH_DASH,  1'b0, ROW_PRED, SYM_SPACE},
			'{CH_DASH,  1'b1, ROW_NONE, SYM_SPACE},
			// four dashes: no such code
			'{CH_DASH,  1'b0, ROW_PRED, SYM_SPACE},
			'{CH_DASH,  1'b0, ROW_PRED, SYM_SPACE},
			'{CH_DASH,  1'b0, ROW_PRED, SYM_SPACE},
			'{CH_DASH,  1'b1, ROW_NONE, SYM_SPACE}
		};

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// walk the directed table
		foreach (dir_tab[i])
			send_char(dir_tab[i].ch, dir_tab[i].fin, dir_tab[i].kind, dir_tab[i].sym);
		char_valid = 1'b0;
		wait_drained();

		// random part: mostly well-formed runs with a separator, some noise
		n = 0;
		while (n < RAND_ITEMS) begin
			in_burst  = ($urandom_range(0, 3) == 0);
			out_burst = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 9) < 7) begin
				len     = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 10)
					: $urandom_range(1, 7);
				fin_end = ($urandom_range(0, 7) == 0);
				for (int k = 0; k < len; k++) begin
					send_char($urandom_range(0, 1) ? CH_DASH : CH_DOT,
						fin_end && (k == len - 1), ROW_PRED, SYM_SPACE);
					n++;
				end
				if (!fin_end) begin
					c = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : CH_SPACE;
					if (c == CH_DOT || c == CH_DASH)
						c = CH_SPACE;
					send_char(c, $urandom_range(0, 15) == 0, ROW_PRED, SYM_SPACE);
					n++;
				end
				if ($urandom_range(0, 4) == 0) begin
					send_char(CH_SPACE, 1'b0, ROW_PRED, SYM_SPACE);
					n++;
				end
			end else begin
				send_char(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0, ROW_PRED,
					SYM_SPACE);
				n++;
			end

			// hold the receiver off while letters keep coming, so the block backs up
			if (n > 300 && !held) begin
				held     = 1'b1;
				rx_hold  = 1'b1;
				in_burst = 1'b1;
				repeat (40) begin
					send_char(8'($urandom_range(97, 122)), 1'b0, ROW_PRED, SYM_SPACE);
					n++;
				end
			end

			// pause the sender until every symbol has gone
			if (n > 600 && !paused) begin
				paused     = 1'b1;
				char_valid = 1'b0;
				wait_drained();
			end
		end
		char_valid = 1'b0;

		// drain, then allow for the pipeline
		wait_drained();
		repeat (10) @(posedge clk);
		while (pending_syms.size() != 0)
			report_mismatch("symbol never arrived", pending_syms.pop_front(), '0);

		if (err_cnt == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
